// File: hw/rtl/mcsr_pkg.sv
// shared types and constants of the machine-mode csr file
package mcsr_pkg;

  localparam int unsigned XLEN = 32;
  localparam int unsigned CSR_AW = 12;

  typedef logic [XLEN-1:0]   word_t;
  typedef logic [CSR_AW-1:0] csr_addr_t;

  // csr address map
  localparam csr_addr_t CSR_MVENDORID = 12'hF11;
  localparam csr_addr_t CSR_MARCHID   = 12'hF12;
  localparam csr_addr_t CSR_MIMPID    = 12'hF13;
  localparam csr_addr_t CSR_MSTATUS   = 12'h300;
  localparam csr_addr_t CSR_MISA      = 12'h301;
  localparam csr_addr_t CSR_MIE       = 12'h304;
  localparam csr_addr_t CSR_MTVEC     = 12'h305;
  localparam csr_addr_t CSR_MSTATUSH  = 12'h310;
  localparam csr_addr_t CSR_MSCRATCH  = 12'h340;
  localparam csr_addr_t CSR_MEPC      = 12'h341;
  localparam csr_addr_t CSR_MCAUSE    = 12'h342;
  localparam csr_addr_t CSR_MTVAL     = 12'h343;
  localparam csr_addr_t CSR_MIP       = 12'h344;
  localparam csr_addr_t CSR_KADDR     = 12'h800;

  localparam word_t MISA_VALUE   = 32'h4010_0100;
  localparam word_t KADDR_RESET  = 32'hFFFF_FFFF;

  // bits of the kind field
  localparam int unsigned KIND_WRITE_BIT = 0;
  localparam int unsigned KIND_TRAP_BIT  = 1;

  typedef struct packed {
    logic [1:0] kind;
    csr_addr_t  write_addr;
    word_t      write_data;
    word_t      trap_status;
    word_t      trap_pending;
    word_t      trap_pc;
    word_t      trap_cause;
    word_t      trap_value;
    csr_addr_t  read_addr_a;
    csr_addr_t  read_addr_b;
  } mcsr_item_t;

  typedef struct packed {
    logic      wr_en;
    csr_addr_t wr_addr;
    word_t     wr_data;
    logic      trap_en;
    word_t     trap_status;
    word_t     trap_pending;
    word_t     trap_pc;
    word_t     trap_cause;
    word_t     trap_value;
  } mcsr_upd_t;

  typedef struct packed {
    word_t exception_pc;
    word_t status;
    word_t trap_vector;
    word_t pending;
    word_t cause;
    word_t kernel_addr;
  } mcsr_view_t;

  typedef struct packed {
    word_t      read_data_a;
    word_t      read_data_b;
    mcsr_view_t view;
  } mcsr_result_t;

endpackage

// File: hw/rtl/mcsr_if.sv
// valid/ready channel interfaces for the csr file item and result beats
interface mcsr_in_if;
  import mcsr_pkg::*;
  logic      valid;
  logic      ready;
  logic [1:0] kind;
  csr_addr_t write_addr;
  word_t     write_data;
  word_t     trap_status;
  word_t     trap_pending;
  word_t     trap_pc;
  word_t     trap_cause;
  word_t     trap_value;
  csr_addr_t read_addr_a;
  csr_addr_t read_addr_b;

  modport source (
    output valid, kind, write_addr, write_data, trap_status, trap_pending,
           trap_pc, trap_cause, trap_value, read_addr_a, read_addr_b,
    input  ready
  );
  modport sink (
    input  valid, kind, write_addr, write_data, trap_status, trap_pending,
           trap_pc, trap_cause, trap_value, read_addr_a, read_addr_b,
    output ready
  );
endinterface

interface mcsr_out_if;
  import mcsr_pkg::*;
  logic  valid;
  logic  ready;
  word_t read_data_a;
  word_t read_data_b;
  word_t exception_pc_out;
  word_t status_out;
  word_t trap_vector_out;
  word_t pending_out;
  word_t cause_out;
  word_t kernel_addr_out;

  modport source (
    output valid, read_data_a, read_data_b, exception_pc_out, status_out,
           trap_vector_out, pending_out, cause_out, kernel_addr_out,
    input  ready
  );
  modport sink (
    input  valid, read_data_a, read_data_b, exception_pc_out, status_out,
           trap_vector_out, pending_out, cause_out, kernel_addr_out,
    output ready
  );
endinterface

// File: hw/rtl/mcsr_regs.sv
// csr state registers with two read ports, write decode and trap update
module mcsr_regs
  import mcsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  mcsr_upd_t  upd_i,
  input  csr_addr_t  rd_addr_a_i,
  input  csr_addr_t  rd_addr_b_i,
  output word_t      rd_data_a_o,
  output word_t      rd_data_b_o,
  output mcsr_view_t view_o
);

  word_t status_r,   status_nxt;
  word_t int_en_r,   int_en_nxt;
  word_t tvec_r,     tvec_nxt;
  word_t epc_r,      epc_nxt;
  word_t cause_r,    cause_nxt;
  word_t tval_r,     tval_nxt;
  word_t pending_r,  pending_nxt;
  word_t scratch_r,  scratch_nxt;
  word_t kaddr_r,    kaddr_nxt;

  function automatic word_t csr_read(input csr_addr_t addr,
                                     input word_t status, input word_t int_en,
                                     input word_t tvec, input word_t scratch,
                                     input word_t epc, input word_t cause,
                                     input word_t tval, input word_t pending,
                                     input word_t kaddr);
    word_t data;
    unique case (addr)
      CSR_MSTATUS:  data = status;
      CSR_MISA:     data = MISA_VALUE;
      CSR_MIE:      data = int_en;
      CSR_MTVEC:    data = tvec;
      CSR_MSCRATCH: data = scratch;
      CSR_MEPC:     data = epc;
      CSR_MCAUSE:   data = cause;
      CSR_MTVAL:    data = tval;
      CSR_MIP:      data = pending;
      CSR_KADDR:    data = kaddr;
      default:      data = '0;
    endcase
    return data;
  endfunction

  assign rd_data_a_o = csr_read(rd_addr_a_i, status_r, int_en_r, tvec_r, scratch_r,
                                epc_r, cause_r, tval_r, pending_r, kaddr_r);
  assign rd_data_b_o = csr_read(rd_addr_b_i, status_r, int_en_r, tvec_r, scratch_r,
                                epc_r, cause_r, tval_r, pending_r, kaddr_r);

  assign view_o.exception_pc = epc_r;
  assign view_o.status       = status_r;
  assign view_o.trap_vector  = tvec_r;
  assign view_o.pending      = pending_r;
  assign view_o.cause        = cause_r;
  assign view_o.kernel_addr  = kaddr_r;

  always_comb begin
    status_nxt  = status_r;
    int_en_nxt  = int_en_r;
    tvec_nxt    = tvec_r;
    epc_nxt     = epc_r;
    cause_nxt   = cause_r;
    tval_nxt    = tval_r;
    pending_nxt = pending_r;
    scratch_nxt = scratch_r;
    kaddr_nxt   = kaddr_r;
    if (upd_i.wr_en) begin
      unique case (upd_i.wr_addr)
        CSR_MSTATUS:  status_nxt  = upd_i.wr_data;
        CSR_MIE:      int_en_nxt  = upd_i.wr_data;
        CSR_MTVEC:    tvec_nxt    = upd_i.wr_data;
        CSR_MSCRATCH: scratch_nxt = upd_i.wr_data;
        CSR_MEPC:     epc_nxt     = upd_i.wr_data;
        CSR_MCAUSE:   cause_nxt   = upd_i.wr_data;
        CSR_MTVAL:    tval_nxt    = upd_i.wr_data;
        CSR_MIP:      pending_nxt = upd_i.wr_data;
        CSR_KADDR:    kaddr_nxt   = upd_i.wr_data;
        default:      ;
      endcase
    end
    // trap update wins over a write in the same beat
    if (upd_i.trap_en) begin
      status_nxt  = upd_i.trap_status;
      pending_nxt = upd_i.trap_pending;
      epc_nxt     = upd_i.trap_pc;
      cause_nxt   = upd_i.trap_cause;
      tval_nxt    = upd_i.trap_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r  <= '0;
      int_en_r  <= '0;
      tvec_r    <= '0;
      epc_r     <= '0;
      cause_r   <= '0;
      tval_r    <= '0;
      pending_r <= '0;
      scratch_r <= '0;
      kaddr_r   <= KADDR_RESET;
    end else begin
      status_r  <= status_nxt;
      int_en_r  <= int_en_nxt;
      tvec_r    <= tvec_nxt;
      epc_r     <= epc_nxt;
      cause_r   <= cause_nxt;
      tval_r    <= tval_nxt;
      pending_r <= pending_nxt;
      scratch_r <= scratch_nxt;
      kaddr_r   <= kaddr_nxt;
    end
  end

  a_kaddr_reset: assert property (@(posedge clk)
    !rst_n |=> (kaddr_r == KADDR_RESET && status_r == '0))
    else $error("kernel address or mstatus wrong after reset");

  a_trap_wins: assert property (@(posedge clk) disable iff (!rst_n)
    upd_i.trap_en |=> (status_r == $past(upd_i.trap_status) &&
                       epc_r == $past(upd_i.trap_pc)))
    else $error("trap update did not load mstatus and mepc");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!upd_i.wr_en && !upd_i.trap_en) |=>
      (status_r == $past(status_r) && kaddr_r == $past(kaddr_r) &&
       scratch_r == $past(scratch_r)))
    else $error("csr state changed without an update");

endmodule

// File: hw/rtl/machine_csr_file_core.sv
// top level of the machine-mode csr file: item register, csr state, result register
// One item is taken per clock. An accepted beat sits in the item register, where
// both read ports and the status views are looked up from the csr state as it
// stood before this item; on the edge that moves the item into the result
// register, its csr write and trap update are applied, with the trap overriding
// a write to the same register. The result register then offers the result, and
// back-to-back items run at one per clock as long as the result side takes its
// beats; a stalled result holds the item register, which holds the input side.
// Reads never see the same item's own update.
module machine_csr_file_core
  import mcsr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  mcsr_in_if.sink           in_bus,
  mcsr_out_if.source        out_bus
);

  mcsr_item_t   item_r;
  logic         item_vld_r;
  mcsr_result_t res_r;
  mcsr_result_t res_nxt;
  logic         res_vld_r;
  logic         advance;
  logic         in_take;
  mcsr_upd_t    upd;
  word_t        rd_a;
  word_t        rd_b;
  mcsr_view_t   view;

  assign advance      = item_vld_r && (!res_vld_r || out_bus.ready);
  assign in_bus.ready = !item_vld_r || advance;
  assign in_take      = in_bus.valid && in_bus.ready;

  assign upd.wr_en        = advance && item_r.kind[KIND_WRITE_BIT];
  assign upd.wr_addr      = item_r.write_addr;
  assign upd.wr_data      = item_r.write_data;
  assign upd.trap_en      = advance && item_r.kind[KIND_TRAP_BIT];
  assign upd.trap_status  = item_r.trap_status;
  assign upd.trap_pending = item_r.trap_pending;
  assign upd.trap_pc      = item_r.trap_pc;
  assign upd.trap_cause   = item_r.trap_cause;
  assign upd.trap_value   = item_r.trap_value;

  mcsr_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .upd_i       (upd),
    .rd_addr_a_i (item_r.read_addr_a),
    .rd_addr_b_i (item_r.read_addr_b),
    .rd_data_a_o (rd_a),
    .rd_data_b_o (rd_b),
    .view_o      (view)
  );

  assign res_nxt.read_data_a = rd_a;
  assign res_nxt.read_data_b = rd_b;
  assign res_nxt.view        = view;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      if (in_take) begin
        item_vld_r <= 1'b1;
      end else if (advance) begin
        item_vld_r <= 1'b0;
      end
      if (advance) begin
        res_vld_r <= 1'b1;
      end else if (out_bus.ready) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.kind         <= in_bus.kind;
      item_r.write_addr   <= in_bus.write_addr;
      item_r.write_data   <= in_bus.write_data;
      item_r.trap_status  <= in_bus.trap_status;
      item_r.trap_pending <= in_bus.trap_pending;
      item_r.trap_pc      <= in_bus.trap_pc;
      item_r.trap_cause   <= in_bus.trap_cause;
      item_r.trap_value   <= in_bus.trap_value;
      item_r.read_addr_a  <= in_bus.read_addr_a;
      item_r.read_addr_b  <= in_bus.read_addr_b;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_bus.valid            = res_vld_r;
  assign out_bus.read_data_a      = res_r.read_data_a;
  assign out_bus.read_data_b      = res_r.read_data_b;
  assign out_bus.exception_pc_out = res_r.view.exception_pc;
  assign out_bus.status_out       = res_r.view.status;
  assign out_bus.trap_vector_out  = res_r.view.trap_vector;
  assign out_bus.pending_out      = res_r.view.pending;
  assign out_bus.cause_out        = res_r.view.cause;
  assign out_bus.kernel_addr_out  = res_r.view.kernel_addr;

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> res_vld_r)
    else $error("item moved on but no result beat offered");

  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    (item_vld_r && !advance) |=> (item_vld_r && item_r == $past(item_r)))
    else $error("stalled item lost or overwritten");

  a_no_update_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !item_vld_r |-> (!upd.wr_en && !upd.trap_en))
    else $error("csr update without an item");

endmodule

// File: verif/tb_machine_csr_file_core.sv
// testbench for machine_csr_file_core: shadow csr state predicts every result beat
module tb_machine_csr_file_core;
  import mcsr_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned TAIL_CYCLES = 6;

  typedef enum logic [1:0] {KIND_NONE, KIND_WR, KIND_TRAP, KIND_WR_TRAP} kind_e;
  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_COMB, RX_LONG} rx_mode_e;

  localparam csr_addr_t KNOWN_CSRS [14] = '{
    CSR_MVENDORID, CSR_MARCHID, CSR_MIMPID, CSR_MSTATUS, CSR_MISA, CSR_MIE, CSR_MTVEC,
    CSR_MSTATUSH, CSR_MSCRATCH, CSR_MEPC, CSR_MCAUSE, CSR_MTVAL, CSR_MIP, CSR_KADDR
  };
  localparam csr_addr_t WRITABLE_CSRS [9] = '{
    CSR_MSTATUS, CSR_MIE, CSR_MTVEC, CSR_MSCRATCH, CSR_MEPC, CSR_MCAUSE, CSR_MTVAL,
    CSR_MIP, CSR_KADDR
  };
  localparam word_t FILL_WORDS [9] = '{
    32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 32'h8000_0000,
    32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000
  };

  class csr_shadow;
    word_t mstatus_q, mie_q, mtvec_q, mscratch_q, mepc_q, mcause_q, mtval_q, mip_q, kaddr_q;
    mcsr_result_t due_q[$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      mstatus_q  = '0;
      mie_q      = '0;
      mtvec_q    = '0;
      mscratch_q = '0;
      mepc_q     = '0;
      mcause_q   = '0;
      mtval_q    = '0;
      mip_q      = '0;
      kaddr_q    = KADDR_RESET;
      mismatches = 0;
      checked    = 0;
    endfunction

    function word_t peek(csr_addr_t a);
      case (a)
        CSR_MSTATUS:  return mstatus_q;
        CSR_MISA:     return MISA_VALUE;
        CSR_MIE:      return mie_q;
        CSR_MTVEC:    return mtvec_q;
        CSR_MSCRATCH: return mscratch_q;
        CSR_MEPC:     return mepc_q;
        CSR_MCAUSE:   return mcause_q;
        CSR_MTVAL:    return mtval_q;
        CSR_MIP:      return mip_q;
        CSR_KADDR:    return kaddr_q;
        default:      return '0;
      endcase
    endfunction

    // reads and views come from the state before this beat's update
    function void note_item(mcsr_item_t it);
      mcsr_result_t r;
      r.read_data_a       = peek(it.read_addr_a);
      r.read_data_b       = peek(it.read_addr_b);
      r.view.exception_pc = mepc_q;
      r.view.status       = mstatus_q;
      r.view.trap_vector  = mtvec_q;
      r.view.pending      = mip_q;
      r.view.cause        = mcause_q;
      r.view.kernel_addr  = kaddr_q;
      due_q.push_back(r);
      if (it.kind[KIND_WRITE_BIT]) begin
        case (it.write_addr)
          CSR_MSTATUS:  mstatus_q  = it.write_data;
          CSR_MIE:      mie_q      = it.write_data;
          CSR_MTVEC:    mtvec_q    = it.write_data;
          CSR_MSCRATCH: mscratch_q = it.write_data;
          CSR_MEPC:     mepc_q     = it.write_data;
          CSR_MCAUSE:   mcause_q   = it.write_data;
          CSR_MTVAL:    mtval_q    = it.write_data;
          CSR_MIP:      mip_q      = it.write_data;
          CSR_KADDR:    kaddr_q    = it.write_data;
          default: ;
        endcase
      end
      // trap update lands after the write so it wins
      if (it.kind[KIND_TRAP_BIT]) begin
        mstatus_q = it.trap_status;
        mip_q     = it.trap_pending;
        mepc_q    = it.trap_pc;
        mcause_q  = it.trap_cause;
        mtval_q   = it.trap_value;
      end
    endfunction

    function void cmp(string field, word_t want, word_t got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t mismatch on %s: expected %h actual %h", $time, field, want, got);
      end
    endfunction

    function void check_beat(mcsr_result_t got);
      mcsr_result_t want;
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t result beat with nothing expected: expected none actual %h",
                   $time, got);
        return;
      end
      want = due_q.pop_front();
      checked++;
      cmp("read_data_a", want.read_data_a, got.read_data_a);
      cmp("read_data_b", want.read_data_b, got.read_data_b);
      cmp("exception_pc_out", want.view.exception_pc, got.view.exception_pc);
      cmp("status_out", want.view.status, got.view.status);
      cmp("trap_vector_out", want.view.trap_vector, got.view.trap_vector);
      cmp("pending_out", want.view.pending, got.view.pending);
      cmp("cause_out", want.view.cause, got.view.cause);
      cmp("kernel_addr_out", want.view.kernel_addr, got.view.kernel_addr);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  mcsr_in_if  in_bus ();
  mcsr_out_if out_bus ();

  machine_csr_file_core u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  csr_shadow   sb = new();
  mcsr_item_t  stim_q[$];
  int unsigned items_in = 0;
  int unsigned idle_cycles = 0;
  int unsigned directed_count = 0;

  // result side stalls on its own pattern, changing mode when its random countdown runs out
  rx_mode_e    rx_mode = RX_FREE;
  int unsigned rx_left = 0;
  logic [31:0] rx_tick = '0;

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 96);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_FREE:   out_bus.ready <= 1'b1;
      RX_RANDOM: out_bus.ready <= ($urandom_range(0, 3) != 0);
      RX_COMB:   out_bus.ready <= (rx_tick[1:0] != 2'b11);
      RX_LONG:   out_bus.ready <= rx_tick[4];
      default:   out_bus.ready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    mcsr_item_t   it;
    mcsr_result_t beat;
    logic         moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        it.kind         = in_bus.kind;
        it.write_addr   = in_bus.write_addr;
        it.write_data   = in_bus.write_data;
        it.trap_status  = in_bus.trap_status;
        it.trap_pending = in_bus.trap_pending;
        it.trap_pc      = in_bus.trap_pc;
        it.trap_cause   = in_bus.trap_cause;
        it.trap_value   = in_bus.trap_value;
        it.read_addr_a  = in_bus.read_addr_a;
        it.read_addr_b  = in_bus.read_addr_b;
        sb.note_item(it);
        items_in++;
        moved = 1'b1;
      end
      if (out_bus.valid && out_bus.ready) begin
        beat.read_data_a       = out_bus.read_data_a;
        beat.read_data_b       = out_bus.read_data_b;
        beat.view.exception_pc = out_bus.exception_pc_out;
        beat.view.status       = out_bus.status_out;
        beat.view.trap_vector  = out_bus.trap_vector_out;
        beat.view.pending      = out_bus.pending_out;
        beat.view.cause        = out_bus.cause_out;
        beat.view.kernel_addr  = out_bus.kernel_addr_out;
        sb.check_beat(beat);
        moved = 1'b1;
      end
    end
    idle_cycles <= moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t watchdog: no beat moved for %0d cycles, %0d results outstanding",
               $time, idle_cycles, sb.due_q.size());
      $display("[machine_csr_file_core] ERROR");
      $finish;
    end
  end

  function automatic csr_addr_t pick_addr();
    if ($urandom_range(0, 9) < 7) return KNOWN_CSRS[$urandom_range(0, 13)];
    return csr_addr_t'($urandom);
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_item(kind_e k, csr_addr_t wa, word_t wd, word_t tv,
                                     csr_addr_t ra, csr_addr_t rb);
    mcsr_item_t it;
    it.kind         = k;
    it.write_addr   = wa;
    it.write_data   = wd;
    it.trap_status  = tv;
    it.trap_pending = ~tv;
    it.trap_pc      = tv;
    it.trap_cause   = ~tv;
    it.trap_value   = tv ^ 32'h5A5A_5A5A;
    it.read_addr_a  = ra;
    it.read_addr_b  = rb;
    stim_q.push_back(it);
  endfunction

  task automatic put_beat(mcsr_item_t it);
    in_bus.valid        <= 1'b1;
    in_bus.kind         <= it.kind;
    in_bus.write_addr   <= it.write_addr;
    in_bus.write_data   <= it.write_data;
    in_bus.trap_status  <= it.trap_status;
    in_bus.trap_pending <= it.trap_pending;
    in_bus.trap_pc      <= it.trap_pc;
    in_bus.trap_cause   <= it.trap_cause;
    in_bus.trap_value   <= it.trap_value;
    in_bus.read_addr_a  <= it.read_addr_a;
    in_bus.read_addr_b  <= it.read_addr_b;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // bursts of random length, some long, with random gaps between them
  task automatic drive_stim();
    int unsigned burst;
    int unsigned gap;
    while (stim_q.size() != 0) begin
      burst = ($urandom_range(0, 4) == 0) ? 150 : $urandom_range(1, 20);
      for (int unsigned i = 0; i < burst && stim_q.size() != 0; i++)
        put_beat(stim_q.pop_front());
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (sb.due_q.size() != 0);
  endtask

  initial begin
    mcsr_item_t it;
    rst_n               <= 1'b0;
    in_bus.valid        <= 1'b0;
    in_bus.kind         <= KIND_NONE;
    in_bus.write_addr   <= '0;
    in_bus.write_data   <= '0;
    in_bus.trap_status  <= '0;
    in_bus.trap_pending <= '0;
    in_bus.trap_pc      <= '0;
    in_bus.trap_cause   <= '0;
    in_bus.trap_value   <= '0;
    in_bus.read_addr_a  <= '0;
    in_bus.read_addr_b  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset values, then every writable csr read in the same beat as its write
    queue_item(KIND_NONE, CSR_MISA, '1, '1, CSR_MISA, CSR_MVENDORID);
    queue_item(KIND_NONE, CSR_KADDR, '0, '0, CSR_KADDR, CSR_MSTATUSH);
    for (int i = 0; i < 9; i++)
      queue_item(KIND_WR, WRITABLE_CSRS[i], FILL_WORDS[i], '0, WRITABLE_CSRS[i],
                 WRITABLE_CSRS[(i + 8) % 9]);
    // read-only and unknown addresses ignore writes
    queue_item(KIND_WR, CSR_MISA, '0, '0, CSR_MISA, CSR_KADDR);
    queue_item(KIND_WR, CSR_MVENDORID, '1, '0, CSR_MVENDORID, CSR_MARCHID);
    queue_item(KIND_WR, CSR_MSTATUSH, '1, '0, CSR_MSTATUSH, CSR_MIMPID);
    queue_item(KIND_WR, 12'hFFF, '1, '0, 12'hFFF, 12'h000);
    queue_item(KIND_WR, 12'h000, '1, '0, 12'h7FF, 12'hF10);
    // trap alone, trap over a write to the same csr, trap beside an unrelated write
    queue_item(KIND_TRAP, CSR_MSCRATCH, '0, '1, CSR_MEPC, CSR_MCAUSE);
    queue_item(KIND_WR_TRAP, CSR_MSTATUS, 32'h1234_5678, '0, CSR_MSTATUS, CSR_MIP);
    queue_item(KIND_WR_TRAP, CSR_MEPC, 32'hDEAD_BEEF, 32'h0F0F_0F0F, CSR_MEPC, CSR_MTVAL);
    queue_item(KIND_WR_TRAP, CSR_MSCRATCH, 32'hCAFE_F00D, '1, CSR_MSCRATCH, CSR_MSTATUS);
    queue_item(KIND_WR_TRAP, CSR_MTVAL, '0, 32'h8000_0001, CSR_MTVAL, CSR_MCAUSE);
    queue_item(KIND_NONE, CSR_MIP, '1, '0, CSR_MTVAL, CSR_MIP);
    queue_item(KIND_TRAP, CSR_MIE, '1, '0, CSR_MSCRATCH, CSR_KADDR);
    queue_item(KIND_NONE, '0, '0, '0, CSR_MEPC, CSR_MSTATUS);
    directed_count = stim_q.size();
    drive_stim();
    drain();

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      it.kind         = 2'($urandom_range(0, 3));
      it.write_addr   = ($urandom_range(0, 3) != 0) ? WRITABLE_CSRS[$urandom_range(0, 8)]
                                                    : pick_addr();
      it.write_data   = pick_word();
      it.trap_status  = pick_word();
      it.trap_pending = pick_word();
      it.trap_pc      = pick_word();
      it.trap_cause   = pick_word();
      it.trap_value   = pick_word();
      it.read_addr_a  = pick_addr();
      it.read_addr_b  = pick_addr();
      stim_q.push_back(it);
      if (n == RANDOM_ITEMS / 2) begin
        drive_stim();
        drain();
      end
    end
    drive_stim();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.due_q.size() != 0) begin
      $display("%0t results never delivered: expected %0d actual 0",
               $time, sb.due_q.size());
      sb.mismatches++;
    end
    $display("covered %0d directed and %0d random items (writes, traps, both, reads of",
             directed_count, items_in - directed_count);
    $display("known and unknown csrs); %0d result beats checked, %0d mismatches",
             sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("[machine_csr_file_core] OK");
    end else begin
      $display("[machine_csr_file_core] ERROR");
    end
    $finish;
  end

endmodule
